[hw/rtl/rhsv_pkg.sv]
// Shared widths, constants and types for the RGB to HSV converter.
// No dependencies; imported by the channel interfaces and all modules.
package rhsv_pkg;

  // Field widths
  localparam int LEVEL_W = 8;
  localparam int HUE_W   = 16;
  localparam int SAT_W   = 16;

  // Hue sector offsets in units of chroma, and sectors per full turn
  localparam int SECTOR_GREEN = 2;
  localparam int SECTOR_BLUE  = 4;
  localparam int SECTORS      = 6;

  // Width of 6*chroma (at most 1530)
  localparam int SPAN_W = 11;

  // Signed hue numerator before the wrap into [0, 6*chroma)
  localparam int NUM_RAW_W = SPAN_W + 1;

  // Difference of two levels, signed
  localparam int DIFF_W = LEVEL_W + 1;

  // Quotient bits of the restoring dividers: 16 fraction bits plus the integer bit
  localparam int DIV_STEPS = HUE_W + 1;

  // Channel that holds the maximum level
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

endpackage

[hw/rtl/rhsv_if.sv]
// Valid/ready channel interfaces for the RGB to HSV converter.
// Depends on rhsv_pkg for the field widths.
interface rhsv_pix_if;
  import rhsv_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] red_level;
  logic [LEVEL_W-1:0] green_level;
  logic [LEVEL_W-1:0] blue_level;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  input ready);
  modport sink   (input valid, input red_level, input green_level, input blue_level,
                  output ready);
endinterface

interface rhsv_hsv_if;
  import rhsv_pkg::*;

  logic               valid;
  logic               ready;
  logic [HUE_W-1:0]   hue_turn;
  logic [SAT_W-1:0]   saturation;
  logic [LEVEL_W-1:0] value_level;

  modport source (output valid, output hue_turn, output saturation, output value_level,
                  input ready);
  modport sink   (input valid, input hue_turn, input saturation, input value_level,
                  output ready);
endinterface

[hw/rtl/rgb_to_hsv_pixel_converter_core.sv]
// Top level of the RGB to HSV converter: max/min stage, hue numerator stage,
// two pipelined dividers. Depends on rhsv_pkg, rhsv_if and rhsv_divider.
//
// Takes one pixel per clock and gives one HSV result per clock while the
// output is not stalled. Two stages find the maximum, chroma and the hue
// numerator; two 17-stage restoring dividers, one quotient bit per stage,
// set the rest of the latency. A stall on the output freezes every stage at
// once, so no transaction is lost or repeated; while the output holds a
// result that is not taken, in_pix.ready stays low.
module rgb_to_hsv_pixel_converter_core (
  input  logic       clk,
  input  logic       rst_n,
  rhsv_pix_if.sink   in_pix,
  rhsv_hsv_if.source out_hsv
);
  import rhsv_pkg::*;

  localparam int PIPE_D = 2 + DIV_STEPS;

  logic advance;

  // Stage 1: maximum, chroma, sector and level difference
  logic                     s1_valid_r;
  logic [LEVEL_W-1:0]       s1_value_r;
  logic [LEVEL_W-1:0]       s1_chroma_r;
  sector_t                  s1_sector_r;
  logic signed [DIFF_W-1:0] s1_diff_r;

  logic [LEVEL_W-1:0]       max_nxt;
  logic [LEVEL_W-1:0]       min_nxt;
  sector_t                  sector_nxt;
  logic signed [DIFF_W-1:0] diff_nxt;

  // Stage 2: wrapped hue numerator and span
  logic                     s2_valid_r;
  logic [LEVEL_W-1:0]       s2_value_r;
  logic [LEVEL_W-1:0]       s2_chroma_r;
  logic [SPAN_W-1:0]        s2_num_r;
  logic [SPAN_W-1:0]        s2_span_r;

  logic [SPAN_W-1:0]           span_nxt;
  logic [SPAN_W-1:0]           base_nxt;
  logic signed [NUM_RAW_W-1:0] num_raw;
  logic [SPAN_W-1:0]           num_nxt;

  // Valid and value travel beside the dividers
  logic               vld_line_r [DIV_STEPS];
  logic [LEVEL_W-1:0] val_line_r [DIV_STEPS];

  logic [DIV_STEPS-1:0] hue_q;
  logic [DIV_STEPS-1:0] sat_q;

  // Hold every stage while a finished result waits
  assign advance      = !vld_line_r[PIPE_D-3] || out_hsv.ready;
  assign in_pix.ready = advance;

  // Find maximum and minimum; blue wins a tie over green, green over red
  always_comb begin
    logic [LEVEL_W-1:0] r;
    logic [LEVEL_W-1:0] g;
    logic [LEVEL_W-1:0] b;
    r = in_pix.red_level;
    g = in_pix.green_level;
    b = in_pix.blue_level;
    max_nxt = (g > r) ? g : r;
    if (b > max_nxt) max_nxt = b;
    min_nxt = (g < r) ? g : r;
    if (b < min_nxt) min_nxt = b;
    if (max_nxt == b) begin
      sector_nxt = SECT_BLUE;
      diff_nxt   = $signed({1'b0, r}) - $signed({1'b0, g});
    end else if (max_nxt == g) begin
      sector_nxt = SECT_GREEN;
      diff_nxt   = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      sector_nxt = SECT_RED;
      diff_nxt   = $signed({1'b0, g}) - $signed({1'b0, b});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_value_r  <= max_nxt;
      s1_chroma_r <= max_nxt - min_nxt;
      s1_sector_r <= sector_nxt;
      s1_diff_r   <= diff_nxt;
    end
  end

  // Build the hue numerator and wrap it into one turn
  assign span_nxt = SPAN_W'(s1_chroma_r) * SPAN_W'(SECTORS);

  always_comb begin
    case (s1_sector_r)
      SECT_BLUE:  base_nxt = SPAN_W'(s1_chroma_r) * SPAN_W'(SECTOR_BLUE);
      SECT_GREEN: base_nxt = SPAN_W'(s1_chroma_r) * SPAN_W'(SECTOR_GREEN);
      default:    base_nxt = '0;
    endcase
    num_raw = $signed({1'b0, base_nxt}) + NUM_RAW_W'(s1_diff_r);
    if (num_raw < 0) begin
      num_nxt = SPAN_W'(num_raw + $signed({1'b0, span_nxt}));
    end else begin
      num_nxt = SPAN_W'(num_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_value_r  <= s1_value_r;
      s2_chroma_r <= s1_chroma_r;
      s2_num_r    <= num_nxt;
      s2_span_r   <= span_nxt;
    end
  end

  // Hue: num / (6*chroma) with 16 fraction bits
  rhsv_divider #(
    .DEN_W (SPAN_W),
    .STEPS (DIV_STEPS)
  ) u_hue_div (
    .clk   (clk),
    .en    (advance),
    .num_i (s2_num_r),
    .den_i (s2_span_r),
    .quo_o (hue_q)
  );

  // Saturation: chroma / value with 16 fraction bits, halved later
  rhsv_divider #(
    .DEN_W (LEVEL_W),
    .STEPS (DIV_STEPS)
  ) u_sat_div (
    .clk   (clk),
    .en    (advance),
    .num_i (s2_chroma_r),
    .den_i (s2_value_r),
    .quo_o (sat_q)
  );

  // Delay valid and value to match the dividers
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_line
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_line_r[i] <= 1'b0;
        end else if (advance) begin
          vld_line_r[i] <= s2_valid_r;
        end
      end
      always_ff @(posedge clk) begin
        if (advance) val_line_r[i] <= s2_value_r;
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_line_r[i] <= 1'b0;
        end else if (advance) begin
          vld_line_r[i] <= vld_line_r[i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (advance) val_line_r[i] <= val_line_r[i-1];
      end
    end
  end

  // Drive the result channel
  assign out_hsv.valid       = vld_line_r[DIV_STEPS-1];
  assign out_hsv.hue_turn    = hue_q[HUE_W-1:0];
  assign out_hsv.saturation  = sat_q[DIV_STEPS-1:1];
  assign out_hsv.value_level = val_line_r[DIV_STEPS-1];

endmodule

[hw/rtl/rhsv_divider.sv]
// Pipelined restoring divider: one quotient bit per register stage.
// Computes floor(num * 2^(STEPS-1) / den) for num <= den; a zero divisor gives 0.
module rhsv_divider #(
  parameter int DEN_W = rhsv_pkg::LEVEL_W,
  parameter int STEPS = rhsv_pkg::DIV_STEPS
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [STEPS-1:0] quo_o
);
  import rhsv_pkg::*;

  // Stage registers; the last stage keeps no remainder
  logic [DEN_W-1:0] rem_r [STEPS-1];
  logic [DEN_W-1:0] den_r [STEPS];
  logic [STEPS-1:0] quo_r [STEPS];

  // Per-stage inputs
  logic [DEN_W:0]   trial  [STEPS];
  logic [DEN_W-1:0] den_in [STEPS];
  logic [STEPS-1:0] quo_in [STEPS];
  logic             take   [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    // First step compares the numerator as is, later steps shift the remainder
    if (i == 0) begin : g_first
      assign trial[i]  = {1'b0, num_i};
      assign den_in[i] = den_i;
      assign quo_in[i] = '0;
    end else begin : g_next
      assign trial[i]  = {rem_r[i-1], 1'b0};
      assign den_in[i] = den_r[i-1];
      assign quo_in[i] = quo_r[i-1];
    end

    assign take[i] = (trial[i] >= {1'b0, den_in[i]});

    // Advance one quotient bit
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i] <= den_in[i];
        quo_r[i] <= {quo_in[i][STEPS-2:0], take[i]};
      end
    end

    // Keep the partial remainder for the next step
    if (i < STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          if (take[i]) begin
            rem_r[i] <= DEN_W'(trial[i] - {1'b0, den_in[i]});
          end else begin
            rem_r[i] <= trial[i][DEN_W-1:0];
          end
        end
      end
    end
  end

  // Drop the quotient of a zero divisor
  assign quo_o = (den_r[STEPS-1] == '0) ? '0 : quo_r[STEPS-1];

endmodule

[test/rgb_to_hsv_pixel_converter_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for rgb_to_hsv_pixel_converter_core: directed and random pixels
// against an in-bench HSV calculation. Depends on rhsv_pkg, rhsv_if and the core RTL.
module rgb_to_hsv_pixel_converter_core_tb;
  import rhsv_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 5;
  localparam int STALL_LIMIT   = 1000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_OFF_LEN  = 120;
  localparam int RANDOM_PIXELS = 250;
  localparam longint HUE_ONE   = longint'(1) << HUE_W;
  localparam longint SAT_ONE   = longint'(1) << (SAT_W - 1);

  typedef struct packed {
    logic [HUE_W-1:0]   hue_turn;
    logic [SAT_W-1:0]   saturation;
    logic [LEVEL_W-1:0] value_level;
  } hsv_t;

  logic clk;
  logic rst_n;

  rhsv_pix_if pix_ch ();
  rhsv_hsv_if hsv_ch ();

  rgb_to_hsv_pixel_converter_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_ch.sink),
    .out_hsv (hsv_ch.source)
  );

  hsv_t pending_hsv[$];
  int   errors;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_left;
  int   quiet_cycles;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Expected HSV for one pixel
  function automatic hsv_t hsv_of_pixel(logic [LEVEL_W-1:0] red, logic [LEVEL_W-1:0] green,
                                        logic [LEVEL_W-1:0] blue);
    hsv_t    res;
    int      r;
    int      g;
    int      b;
    int      top;
    int      bottom;
    int      chroma;
    int      num;
    int      span;
    sector_t sect;
    r = red;
    g = green;
    b = blue;
    top = r;
    if (g > top) top = g;
    if (b > top) top = b;
    bottom = r;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    chroma = top - bottom;
    res.value_level = top[LEVEL_W-1:0];
    res.saturation = '0;
    res.hue_turn = '0;
    if (top != 0) begin
      res.saturation = SAT_W'((SAT_ONE * chroma) / top);
    end
    if (chroma != 0) begin
      // blue wins a tie over green, green over red
      if (b == top) sect = SECT_BLUE;
      else if (g == top) sect = SECT_GREEN;
      else sect = SECT_RED;
      span = SECTORS * chroma;
      case (sect)
        SECT_BLUE: begin
          num = SECTOR_BLUE * chroma + (r - g);
        end
        SECT_GREEN: begin
          num = SECTOR_GREEN * chroma + (b - r);
        end
        default: begin
          num = g - b;
        end
      endcase
      if (num < 0) num += span;
      res.hue_turn = HUE_W'((HUE_ONE * num) / span);
    end
    return res;
  endfunction

  // Offer one pixel, with random idle cycles ahead of it, and record its expected result
  task automatic send_pixel(input logic [LEVEL_W-1:0] red, input logic [LEVEL_W-1:0] green,
                            input logic [LEVEL_W-1:0] blue);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.red_level   <= red;
    pix_ch.green_level <= green;
    pix_ch.blue_level  <= blue;
    do @(posedge clk); while (!pix_ch.ready);
    pending_hsv.push_back(hsv_of_pixel(red, green, blue));
  endtask

  // Drop valid after the last transaction of a stretch
  task automatic release_pixel_bus();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
  endtask

  // Drive ready: long hold-off when requested, else random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hsv_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
      hsv_ch.ready <= 1'b0;
    end else begin
      hsv_ch.ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    hsv_t want;
    if (rst_n && hsv_ch.valid && hsv_ch.ready) begin
      if (pending_hsv.size() == 0) begin
        $display("%0t: unexpected result: expected none, got hue %0d sat %0d value %0d",
                 $time, hsv_ch.hue_turn, hsv_ch.saturation, hsv_ch.value_level);
        errors++;
      end else begin
        want = pending_hsv.pop_front();
        if (hsv_ch.hue_turn !== want.hue_turn) begin
          $display("%0t: hue_turn mismatch: expected %0d, got %0d",
                   $time, want.hue_turn, hsv_ch.hue_turn);
          errors++;
        end
        if (hsv_ch.saturation !== want.saturation) begin
          $display("%0t: saturation mismatch: expected %0d, got %0d",
                   $time, want.saturation, hsv_ch.saturation);
          errors++;
        end
        if (hsv_ch.value_level !== want.value_level) begin
          $display("%0t: value_level mismatch: expected %0d, got %0d",
                   $time, want.value_level, hsv_ch.value_level);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((pix_ch.valid && pix_ch.ready) || (hsv_ch.valid && hsv_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d results still outstanding", $time, pending_hsv.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Black, white, grays, primaries and the smallest chroma
  task automatic test_extremes();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd170, 8'd85, 8'd85);
  endtask

  // Ties for the maximum, every sector and the negative-numerator wrap
  task automatic test_ties_and_sectors();
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd200, 8'd100);
    send_pixel(8'd100, 8'd200, 8'd200);
    send_pixel(8'd255, 8'd0, 8'd10);
    send_pixel(8'd255, 8'd10, 8'd0);
    send_pixel(8'd10, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd10);
    send_pixel(8'd10, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd10, 8'd255);
    send_pixel(8'd200, 8'd100, 8'd50);
    release_pixel_bus();
  endtask

  // Hold the output off long enough that the pipe fills and input ready drops
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_left = HOLD_OFF_LEN;
    repeat (40) begin
      send_pixel(LEVEL_W'($urandom_range(255)), LEVEL_W'($urandom_range(255)),
                 LEVEL_W'($urandom_range(255)));
    end
    release_pixel_bus();
  endtask

  // Random pixels, with grays and pairs of equal levels mixed in
  task automatic run_random_pixels(input int count);
    logic [LEVEL_W-1:0] r;
    logic [LEVEL_W-1:0] g;
    logic [LEVEL_W-1:0] b;
    repeat (count) begin
      r = LEVEL_W'($urandom_range(255));
      g = LEVEL_W'($urandom_range(255));
      b = LEVEL_W'($urandom_range(255));
      case ($urandom_range(7))
        0: begin
          g = r;
          b = r;
        end
        1: begin
          g = r;
        end
        2: begin
          b = g;
        end
        3: begin
          b = r;
        end
        default: begin
        end
      endcase
      send_pixel(r, g, b);
    end
    release_pixel_bus();
  endtask

  task automatic test_random_free_flow();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_pixels(RANDOM_PIXELS);
  endtask

  task automatic test_random_sender_gaps();
    send_idle_pct = 48;
    recv_stall_pct = 0;
    run_random_pixels(RANDOM_PIXELS);
  endtask

  task automatic test_random_receiver_stalls();
    send_idle_pct = 0;
    recv_stall_pct = 48;
    run_random_pixels(RANDOM_PIXELS);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 38;
    recv_stall_pct = 38;
    run_random_pixels(RANDOM_PIXELS);
  endtask

  // Reset, run every test, drain and report
  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    pix_ch.valid = 1'b0;
    pix_ch.red_level = '0;
    pix_ch.green_level = '0;
    pix_ch.blue_level = '0;
    hsv_ch.ready = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_ties_and_sectors();
    test_output_hold_off();
    test_random_free_flow();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idle();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (pending_hsv.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/rhsv_pkg.sv
hw/rtl/rhsv_if.sv
hw/rtl/rhsv_divider.sv
hw/rtl/rgb_to_hsv_pixel_converter_core.sv
test/rgb_to_hsv_pixel_converter_core_tb.sv
